### sv/spmc_pkg.sv
// Shared types and constants for the spin and motion classifier.
package spmc_pkg;

	typedef struct packed {
		logic signed [11:0] rate_z;
		logic               at_rest;
		logic        [31:0] time_us;
	} sample_t;

	typedef struct packed {
		logic        [1:0]  motion_mode;
		logic               moving;
		logic               sleep_active;
		logic signed [31:0] torque_out;
		logic               zero_interval;
	} result_t;

	localparam logic [1:0] MODE_REST   = 2'd0;
	localparam logic [1:0] MODE_MOTION = 2'd1;
	localparam logic [1:0] MODE_SPIN   = 2'd2;

	localparam logic [1:0] CFG_SPIN_THRESHOLD   = 2'd0;
	localparam logic [1:0] CFG_SLEEP_THRESHOLD  = 2'd1;
	localparam logic [1:0] CFG_STATIONARY_RESET = 2'd2;

	localparam logic signed [11:0] SPIN_THRESHOLD_RST   = 12'sd400;
	localparam logic        [15:0] SLEEP_THRESHOLD_RST  = 16'd1000;
	localparam logic        [15:0] STATIONARY_RESET_RST = 16'd2000;

	localparam logic signed [11:0] MOVING_LIMIT = 12'sd200;
	localparam logic        [16:0] SLEEP_STEP   = 17'd10;
	localparam logic        [16:0] COUNT_MAX    = 17'h1FFFF;

	localparam logic [13:0] TORQUE_GAIN = 14'd8748;
	localparam logic signed [8:0] FILT_NEW = 9'sd243;
	localparam logic signed [8:0] FILT_OLD = 9'sd13;

	// Magnitude of gain * 256 * rate difference needs 34 bits
	localparam int DIV_W  = 34;
	localparam int DIVR_W = 32;
	localparam int CNT_W  = $clog2(DIV_W + 1);

endpackage

### sv/spmc_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module spmc_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [spmc_pkg::DIV_W-1:0]        dividend,
	input  logic [spmc_pkg::DIVR_W-1:0]       divisor,
	output logic                              done,
	output logic [spmc_pkg::DIV_W-1:0]        quotient
);
	import spmc_pkg::*;

	logic [DIVR_W-1:0] rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DIVR_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DIVR_W:0]   trial;
	logic [DIVR_W:0]   diff;
	logic              qbit;

	// Bring down the next dividend bit beside the partial remainder
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign qbit  = !diff[DIVR_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				quo_q  <= dividend;
				dvs_q  <= divisor;
			end else if (busy_q) begin
				rem_q <= qbit ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], qbit};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### sv/spin_motion_classifier.sv
// Top level: gyro sample classifier with filtered torque and stationary counter.
// One sample is taken at a time; the next one is accepted only after the last has loaded
// the result register. The steps are: capture, the gain multiply, the bit-serial
// divider that forms the rate derivative, taking the quotient, the low-pass filter
// multiply and sum, and the load of the result register. A sample with zero elapsed
// time skips the divider.
// The result register holds a finished beat while the next sample is already being
// worked on. A held beat stops the block only once the next result is ready to load.
module spin_motion_classifier (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  spmc_pkg::sample_t   sample,
	output logic                result_valid,
	input  logic                result_stall,
	output spmc_pkg::result_t   result,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_wdata
);
	import spmc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FMUL,
		ST_FSUM,
		ST_DONE
	} state_t;

	state_t state_q;

	logic signed [11:0] spin_th_q;
	logic        [15:0] sleep_th_q;
	logic        [15:0] stat_rst_q;

	logic signed [11:0] prev_rate_q;
	logic        [31:0] prev_time_q;
	logic signed [31:0] filt_q;
	logic        [16:0] count_q;

	logic        [1:0]  mode_q;
	logic               moving_q;
	logic               sleep_q;
	logic               zero_q;
	logic               neg_q;
	logic        [11:0] absdiff_q;
	logic        [31:0] dt_q;
	logic signed [31:0] raw_q;
	logic signed [40:0] pnew_q;
	logic signed [40:0] pold_q;

	logic               result_valid_q;
	result_t            result_q;

	logic               div_start;
	logic               div_done;
	logic [DIV_W-1:0]   div_quo;
	logic [DIV_W-1:0]   mag;

	// Capture-time arithmetic
	logic signed [12:0] rdiff;
	logic        [12:0] rdiff_neg;
	logic        [31:0] dt;
	logic        [1:0]  mode_n;
	logic               moving_n;
	logic        [17:0] cnt_inc;
	logic        [16:0] cnt_one;
	logic        [16:0] cnt_base;
	logic        [17:0] cnt_step;
	logic        [16:0] cnt_n;
	logic               sleep_n;
	logic signed [31:0] raw_n;
	logic signed [40:0] fsum;
	logic               take;

	assign take = sample_valid && !sample_stall;

	assign rdiff     = 13'(sample.rate_z) - 13'(prev_rate_q);
	assign rdiff_neg = -rdiff;
	assign dt        = sample.time_us - prev_time_q;

	always_comb begin
		if (sample.rate_z > spin_th_q)
			mode_n = MODE_SPIN;
		else if (sample.at_rest)
			mode_n = MODE_REST;
		else
			mode_n = MODE_MOTION;
	end

	assign moving_n = sample.rate_z > MOVING_LIMIT;

	// Stationary count: saturates, clears when moving, optional restart, then the sleep step
	always_comb begin
		cnt_inc  = {1'b0, count_q} + 18'd1;
		cnt_one  = cnt_inc[17] ? COUNT_MAX : cnt_inc[16:0];
		cnt_base = (cnt_one > {1'b0, stat_rst_q}) ? 17'd0 : cnt_one;
		cnt_step = {1'b0, cnt_base} + {1'b0, SLEEP_STEP};
		sleep_n  = 1'b0;
		cnt_n    = cnt_one;
		if (moving_n) begin
			cnt_n = '0;
		end else if (cnt_one > {1'b0, sleep_th_q}) begin
			sleep_n = 1'b1;
			cnt_n   = cnt_step[17] ? COUNT_MAX : cnt_step[16:0];
		end
	end

	// Saturate the derivative magnitude and restore its sign
	always_comb begin
		if (!neg_q) begin
			raw_n = (div_quo[DIV_W-1:31] != '0) ? 32'sh7FFFFFFF : $signed(div_quo[31:0]);
		end else begin
			if (div_quo[DIV_W-1:32] != '0 || (div_quo[31] && div_quo[30:0] != '0))
				raw_n = 32'sh80000000;
			else
				raw_n = $signed(-div_quo[31:0]);
		end
	end

	assign fsum = pnew_q + pold_q;

	// Gain times rate difference, scaled to Q8, loaded straight into the divider
	assign mag = {26'(TORQUE_GAIN) * 26'(absdiff_q), 8'd0};

	assign div_start = (state_q == ST_MUL) && !zero_q;

	spmc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag),
		.divisor  (dt_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spin_th_q  <= SPIN_THRESHOLD_RST;
			sleep_th_q <= SLEEP_THRESHOLD_RST;
			stat_rst_q <= STATIONARY_RESET_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SPIN_THRESHOLD:   spin_th_q  <= $signed(cfg_wdata[11:0]);
				CFG_SLEEP_THRESHOLD:  sleep_th_q <= cfg_wdata;
				CFG_STATIONARY_RESET: stat_rst_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			prev_rate_q    <= '0;
			prev_time_q    <= '0;
			filt_q         <= '0;
			count_q        <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
			mode_q         <= MODE_REST;
			moving_q       <= 1'b0;
			sleep_q        <= 1'b0;
			zero_q         <= 1'b0;
			neg_q          <= 1'b0;
			absdiff_q      <= '0;
			dt_q           <= '0;
			raw_q          <= '0;
			pnew_q         <= '0;
			pold_q         <= '0;
		end else begin
			if (state_q == ST_DONE && (!result_valid_q || !result_stall))
				result_valid_q <= 1'b1;
			else if (result_valid_q && !result_stall)
				result_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						mode_q      <= mode_n;
						moving_q    <= moving_n;
						sleep_q     <= sleep_n;
						count_q     <= cnt_n;
						zero_q      <= (dt == '0);
						dt_q        <= dt;
						neg_q       <= rdiff[12];
						absdiff_q   <= rdiff[12] ? rdiff_neg[11:0] : rdiff[11:0];
						prev_rate_q <= sample.rate_z;
						prev_time_q <= sample.time_us;
						state_q     <= ST_MUL;
					end
				end
				ST_MUL: begin
					raw_q <= '0;
					// Zero interval: derivative is zero, skip the divider
					state_q <= zero_q ? ST_FMUL : ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						raw_q   <= raw_n;
						state_q <= ST_FMUL;
					end
				end
				ST_FMUL: begin
					pnew_q  <= 41'(raw_q) * 41'(FILT_NEW);
					pold_q  <= 41'(filt_q) * 41'(FILT_OLD);
					state_q <= ST_FSUM;
				end
				ST_FSUM: begin
					// Arithmetic drop of eight bits gives the floor of sum / 256
					filt_q  <= fsum[39:8];
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!result_valid_q || !result_stall) begin
						result_q.motion_mode   <= mode_q;
						result_q.moving        <= moving_q;
						result_q.sleep_active  <= sleep_q;
						result_q.torque_out    <= filt_q;
						result_q.zero_interval <= zero_q;
						state_q                <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign sample_stall = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
